>>> rtl/itrd_pkg.sv
// Shared types, constants and helpers of the integer-to-radix-digits unit.
package itrd_pkg;

  localparam int unsigned VALUE_BITS = 31;
  localparam int unsigned RADIX_W    = 5;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned CHAR_W     = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

  // radix >= 2, so one digit per value bit at most
  localparam int unsigned MAX_DIGITS = VALUE_BITS;
  localparam int unsigned CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int unsigned IDX_W      = $clog2(MAX_DIGITS);

  // divider retires this many quotient bits per cycle
  localparam int unsigned DIV_STEP   = 8;
  localparam int unsigned DIV_CYCLES = (VALUE_BITS + DIV_STEP - 1) / DIV_STEP;
  localparam int unsigned DIV_QW     = DIV_CYCLES * DIV_STEP;
  localparam int unsigned DIV_CNT_W  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  localparam int unsigned FQ_DEPTH = 2;
  localparam int unsigned FQ_PTR_W = $clog2(FQ_DEPTH);
  localparam int unsigned FQ_CNT_W = $clog2(FQ_DEPTH + 1);

  localparam logic [CHAR_W-1:0] CHAR_ZERO = CHAR_W'(8'h30);
  localparam logic [CHAR_W-1:0] CHAR_NINE = CHAR_W'(8'h39);
  localparam logic [CHAR_W-1:0] CHAR_A    = CHAR_W'(8'h41);
  localparam logic [CHAR_W-1:0] CHAR_F    = CHAR_W'(8'h46);

  localparam logic [CHAR_W-1:0] DIGIT_CHARS [16] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
  };

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [RADIX_W-1:0]    radix;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last_digit;
  } out_item_t;

  // queued job: radix already clamped into 2..16
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [RADIX_W-1:0]    radix;
  } work_t;

  typedef struct packed {
    logic                  start;
    logic [VALUE_BITS-1:0] dividend;
    logic [RADIX_W-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [VALUE_BITS-1:0] quotient;
    logic [DIGIT_W-1:0]    remainder;
  } div_rsp_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_EMIT
  } back_state_e;

  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    return DIGIT_CHARS[d];
  endfunction

endpackage

>>> rtl/itrd_front.sv
// Front end: accepts transactions, clamps the radix, queues jobs for the back end.
module itrd_front import itrd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  in_item_t in_item_i,
  output logic     work_valid_o,
  output work_t    work_o,
  input  logic     work_take_i
);

  work_t                fifo_q [FQ_DEPTH];
  logic [FQ_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FQ_CNT_W-1:0]  cnt_q;
  logic                 wr_en, rd_en;
  work_t                job;

  always_comb begin
    job.value = in_item_i.value;
    if (in_item_i.radix < RADIX_MIN) begin
      job.radix = RADIX_MIN;
    end else if (in_item_i.radix > RADIX_MAX) begin
      job.radix = RADIX_MAX;
    end else begin
      job.radix = in_item_i.radix;
    end
  end

  assign full         = (cnt_q == FQ_CNT_W'(FQ_DEPTH));
  assign wr_en        = push && !full;
  assign work_valid_o = (cnt_q != '0);
  assign rd_en        = work_take_i && work_valid_o;
  assign work_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= (wr_ptr_q == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_q <= (rd_ptr_q == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fifo_q[wr_ptr_q] <= job;
    end
  end

endmodule

>>> rtl/itrd_div.sv
// Iterative restoring divider by a small radix, several quotient bits per cycle.
module itrd_div import itrd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_QW-1:0]    q_q, q_n;
  logic [DIGIT_W-1:0]   rem_q, rem_n;
  logic [RADIX_W-1:0]   dvs_q;
  logic [DIGIT_W:0]     part;

  // one restoring step per quotient bit
  always_comb begin
    q_n   = q_q;
    rem_n = rem_q;
    part  = '0;
    for (int i = 0; i < DIV_STEP; i++) begin
      part = {rem_n, q_n[DIV_QW-1]};
      q_n  = {q_n[DIV_QW-2:0], 1'b0};
      if (part >= dvs_q) begin
        part   = part - dvs_q;
        q_n[0] = 1'b1;
      end
      rem_n = part[DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      q_q   <= DIV_QW'(req_i.dividend);
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      q_q   <= q_n;
      rem_q <= rem_n;
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = q_q[VALUE_BITS-1:0];
  assign rsp_o.remainder = rem_q;

endmodule

>>> rtl/itrd_back.sv
// Back end: drives the divider, stacks remainders, emits digits most significant first.
module itrd_back import itrd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      work_valid_i,
  input  work_t     work_i,
  output logic      work_take_o,
  output div_req_t  div_req_o,
  input  div_rsp_t  div_rsp_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  back_state_e         state_q, state_d;
  logic [CNT_W-1:0]    cnt_q;
  logic [IDX_W-1:0]    idx_q;
  logic [RADIX_W-1:0]  radix_q;
  logic [DIGIT_W-1:0]  stack_q [MAX_DIGITS];
  out_item_t           out_q;
  logic                out_valid_q;
  logic                push_digit, load_out, q_zero;

  assign q_zero = (div_rsp_i.quotient == '0);

  always_comb begin
    state_d            = state_q;
    work_take_o        = 1'b0;
    div_req_o.start    = 1'b0;
    div_req_o.dividend = work_i.value;
    div_req_o.divisor  = work_i.radix;
    push_digit         = 1'b0;
    load_out           = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (work_valid_i) begin
          work_take_o     = 1'b1;
          div_req_o.start = 1'b1;
          state_d         = B_DIV;
        end
      end
      B_DIV: begin
        if (div_rsp_i.done) begin
          push_digit = 1'b1;
          if (q_zero) begin
            state_d = B_EMIT;
          end else begin
            div_req_o.start    = 1'b1;
            div_req_o.dividend = div_rsp_i.quotient;
            div_req_o.divisor  = radix_q;
          end
        end
      end
      B_EMIT: begin
        if (!out_valid_q || pop) begin
          load_out = 1'b1;
          if (idx_q == '0) begin
            state_d = B_IDLE;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (work_take_o) begin
        cnt_q <= '0;
      end else if (push_digit) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (push_digit && q_zero) begin
        idx_q <= cnt_q[IDX_W-1:0];
      end else if (load_out) begin
        idx_q <= idx_q - 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (work_take_o) begin
      radix_q <= work_i.radix;
    end
    if (push_digit) begin
      stack_q[cnt_q[IDX_W-1:0]] <= div_rsp_i.remainder;
    end
    if (load_out) begin
      out_q.digit_char <= digit_to_char(stack_q[idx_q]);
      out_q.last_digit <= (idx_q == '0);
    end
  end

  assign empty      = !out_valid_q;
  assign out_item_o = out_q;

  a_rem_below_radix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_DIV && div_rsp_i.done) |-> ({1'b0, div_rsp_i.remainder} < radix_q))
    else $error("remainder not below radix");

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_digit |-> (cnt_q < CNT_W'(MAX_DIGITS)))
    else $error("digit stack overflow");

  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_q.digit_char >= CHAR_ZERO && out_q.digit_char <= CHAR_NINE) ||
                     (out_q.digit_char >= CHAR_A && out_q.digit_char <= CHAR_F)))
    else $error("illegal digit character");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && idx_q == '0) |=> (state_q == B_IDLE && out_q.last_digit))
    else $error("run did not end on last digit");

endmodule

>>> rtl/integer_to_radix_digits_unit.sv
// Top level of the integer-to-radix-digits unit: front queue, divider and digit emitter.
//
// Each transaction pushed in carries a value (VALUE_BITS bits) and a radix; a radix
// below 2 is taken as 2 and one above 16 as 16. The unit divides the value by the
// radix until the quotient is zero and pops out one transaction per digit, most
// significant first, as an ASCII character '0'-'9' or 'A'-'F'; last_digit marks the
// least significant digit. A zero value gives the single digit '0'. A conversion of
// D digits (1 to VALUE_BITS) runs one division per digit on the shared divider, which
// retires DIV_STEP quotient bits per cycle while busy, then emits the stacked digits
// one by one as the result register frees up. A two-entry input queue takes
// new transactions while a conversion runs, and the one-entry result register lets
// the divider start on the next value while the final digit waits to be popped.
// There is no reset sweep; the unit is ready as soon as reset is released.
module integer_to_radix_digits_unit import itrd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  // input queue side
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item_i,
  // result queue side
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  logic     work_valid;
  logic     work_take;
  work_t    work;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // accept, clamp the radix, buffer jobs
  itrd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .in_item_i    (in_item_i),
    .work_valid_o (work_valid),
    .work_o       (work),
    .work_take_i  (work_take)
  );

  // shared iterative divider
  itrd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // sequencing, remainder stack and result register
  itrd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .work_valid_i (work_valid),
    .work_i       (work),
    .work_take_o  (work_take),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .empty        (empty),
    .pop          (pop),
    .out_item_o   (out_item_o)
  );

endmodule
